// ===== hw/rtl/nlt_pkg.sv =====
`default_nettype none

package nlt_pkg;

  // Table geometry.
  localparam int NUM_PORTS = 4;
  localparam int IDX_W     = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
  // A table request reports at most four ports.
  localparam int TBL_N     = (NUM_PORTS < 4) ? NUM_PORTS : 4;
  localparam int MASK_W    = 4;
  localparam int TIMER_W   = 16;
  localparam int ADDR_W    = 64;

  localparam logic [TIMER_W-1:0] TIMEOUT_RESET = 16'd1000;

  typedef enum logic [1:0] {
    CMD_ANNOUNCE  = 2'd0,
    CMD_HEARTBEAT = 2'd1,
    CMD_TICK      = 2'd2,
    CMD_TABLE     = 2'd3
  } nlt_cmd_t;

  // One request on the input channel.
  typedef struct packed {
    nlt_cmd_t           command;
    logic [1:0]         port;
    logic               is_ack;
    logic [ADDR_W-1:0]  addr_hi;
    logic [ADDR_W-1:0]  addr_lo;
  } nlt_request_t;

  // One result on the output channel.
  typedef struct packed {
    logic               ack_wanted;
    logic               send_discover;
    logic [MASK_W-1:0]  expired_mask;
    logic [1:0]         entry_port;
    logic [ADDR_W-1:0]  entry_addr_hi;
    logic [ADDR_W-1:0]  entry_addr_lo;
    logic               entry_reachable;
    logic               last;
  } nlt_result_t;

  // One port's entry as seen by the update unit.
  typedef struct packed {
    logic [ADDR_W-1:0]  addr_hi;
    logic [ADDR_W-1:0]  addr_lo;
    logic               reachable;
    logic [TIMER_W-1:0] count;
    logic               active;
  } nlt_entry_t;

  // Status from the update unit back to the sequencer.
  typedef struct packed {
    logic match;
    logic expired;
  } nlt_unit_flags_t;

endpackage

`default_nettype wire

// ===== hw/rtl/nlt_update_unit.sv =====
`default_nettype none

module nlt_update_unit
  import nlt_pkg::*;
(
  input  nlt_cmd_t                 cmd,
  input  logic [ADDR_W-1:0]        req_addr_hi,
  input  logic [ADDR_W-1:0]        req_addr_lo,
  input  logic [TIMER_W-1:0]       timeout_ticks,
  input  nlt_entry_t               entry_cur,
  output nlt_entry_t               entry_nxt,
  output nlt_unit_flags_t          flags
);

  logic addr_eq;
  logic count_low;

  // The one wide compare and the one timer decrement, shared by all ports.
  assign addr_eq   = (entry_cur.addr_hi == req_addr_hi) && (entry_cur.addr_lo == req_addr_lo);
  assign count_low = (entry_cur.count <= TIMER_W'(1));

  // Work out the entry's next contents for the current command.
  always_comb begin
    entry_nxt     = entry_cur;
    flags.match   = addr_eq;
    flags.expired = 1'b0;
    case (cmd)
      CMD_ANNOUNCE: begin
        entry_nxt.addr_hi   = req_addr_hi;
        entry_nxt.addr_lo   = req_addr_lo;
        entry_nxt.reachable = 1'b1;
        entry_nxt.count     = timeout_ticks;
        entry_nxt.active    = 1'b1;
      end
      CMD_HEARTBEAT: begin
        if (addr_eq) begin
          entry_nxt.reachable = 1'b1;
          entry_nxt.count     = timeout_ticks;
          entry_nxt.active    = 1'b1;
        end
      end
      CMD_TICK: begin
        if (entry_cur.active) begin
          if (count_low) begin
            entry_nxt.count     = '0;
            entry_nxt.active    = 1'b0;
            entry_nxt.reachable = 1'b0;
            flags.expired       = 1'b1;
          end else begin
            entry_nxt.count = entry_cur.count - TIMER_W'(1);
          end
        end
      end
      CMD_TABLE: begin
        entry_nxt = entry_cur;
      end
      default: begin
        entry_nxt = entry_cur;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/neighbor_liveness_table.sv =====
// Channel  Direction  Handshake          Payload
// in_      in         in_valid/in_stall  nlt_request_t (command, port, is_ack, address)
// out_     out        out_valid/out_stall nlt_result_t (flags, mask, entry, last)
// cfg_     in         cfg_valid/cfg_ready 16-bit timeout_ticks
//
// A request is taken while the sequencer is idle, then a sequencer walks the port table through
// one shared update unit, one port per cycle while no output stall holds it. Announce and heartbeat
// visit the named port only, a tick visits every port and a table request the first min(NUM_PORTS, 4).
// Output stalls hold the walk, since each result waits for the output register.
// The next request is taken while the final result still waits in that register.
// Synchronous active-low reset clears the table, the timers and the timeout to 1000.
`default_nettype none

module neighbor_liveness_table
  import nlt_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  nlt_request_t       in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output nlt_result_t        out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [TIMER_W-1:0] cfg_data
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WALK = 2'b10
  } nlt_state_t;

  nlt_state_t         state_r, state_nxt;
  nlt_request_t       req_r;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [MASK_W-1:0]  mask_r, mask_nxt;
  logic [TIMER_W-1:0] tmo_r;

  logic [ADDR_W-1:0]  addr_hi_r [NUM_PORTS];
  logic [ADDR_W-1:0]  addr_lo_r [NUM_PORTS];
  logic               reach_r   [NUM_PORTS];
  logic [TIMER_W-1:0] count_r   [NUM_PORTS];
  logic               active_r  [NUM_PORTS];

  logic               out_valid_r;
  nlt_result_t        out_data_r;

  nlt_entry_t         entry_cur, entry_nxt;
  nlt_unit_flags_t    flags;
  nlt_result_t        res;
  logic               idx_ok;
  logic               port_ok;
  logic               last_step;
  logic               emit;
  logic               out_free;
  logic               go;
  logic               wr_en;
  logic [MASK_W-1:0]  new_bit;

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;

  // Timeout register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tmo_r <= TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      tmo_r <= cfg_data;
    end
  end

  // Read the entry the sequencer is pointing at.
  assign idx_ok  = (int'(idx_r) < NUM_PORTS);
  assign port_ok = (int'(req_r.port) < NUM_PORTS);

  always_comb begin
    entry_cur = '0;
    if (idx_ok) begin
      entry_cur.addr_hi   = addr_hi_r[idx_r];
      entry_cur.addr_lo   = addr_lo_r[idx_r];
      entry_cur.reachable = reach_r[idx_r];
      entry_cur.count     = count_r[idx_r];
      entry_cur.active    = active_r[idx_r];
    end
  end

  nlt_update_unit u_unit (
    .cmd           (req_r.command),
    .req_addr_hi   (req_r.addr_hi),
    .req_addr_lo   (req_r.addr_lo),
    .timeout_ticks (tmo_r),
    .entry_cur     (entry_cur),
    .entry_nxt     (entry_nxt),
    .flags         (flags)
  );

  // Step control: when this step finishes the request and when it gives a result.
  always_comb begin
    case (req_r.command)
      CMD_TICK:  last_step = (idx_r == IDX_W'(NUM_PORTS - 1));
      CMD_TABLE: last_step = (idx_r == IDX_W'(TBL_N - 1));
      default:   last_step = 1'b1;
    endcase
  end

  assign emit    = (req_r.command == CMD_TABLE) || last_step;
  assign go      = (state_r == ST_WALK) && (!emit || out_free);
  assign wr_en   = go && idx_ok &&
                   ((req_r.command == CMD_TICK) ||
                    (((req_r.command == CMD_ANNOUNCE) || (req_r.command == CMD_HEARTBEAT))
                     && port_ok));
  assign new_bit = flags.expired ? (MASK_W'(1) << idx_r) : '0;

  // Result for the current step.
  always_comb begin
    res      = '0;
    res.last = last_step;
    case (req_r.command)
      CMD_ANNOUNCE: begin
        res.ack_wanted = port_ok && !req_r.is_ack;
      end
      CMD_HEARTBEAT: begin
        res.send_discover = port_ok && !flags.match;
      end
      CMD_TICK: begin
        res.expired_mask = mask_r | new_bit;
      end
      CMD_TABLE: begin
        if (entry_cur.reachable) begin
          res.entry_port      = 2'(idx_r);
          res.entry_addr_hi   = entry_cur.addr_hi;
          res.entry_addr_lo   = entry_cur.addr_lo;
          res.entry_reachable = 1'b1;
        end
      end
      default: begin
        res = '0;
      end
    endcase
  end

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    mask_nxt  = mask_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_WALK;
          mask_nxt  = '0;
          if ((in_data.command == CMD_TICK) || (in_data.command == CMD_TABLE)) begin
            idx_nxt = '0;
          end else begin
            idx_nxt = IDX_W'(in_data.port);
          end
        end
      end
      ST_WALK: begin
        if (go) begin
          mask_nxt = mask_r | new_bit;
          idx_nxt  = idx_r + IDX_W'(1);
          if (last_step) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
      mask_r  <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      mask_r  <= mask_nxt;
    end
  end

  // Capture the request when it is taken.
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      req_r <= in_data;
    end
  end

  // Port table, written back from the update unit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < NUM_PORTS; p++) begin
        addr_hi_r[p] <= '0;
        addr_lo_r[p] <= '0;
        reach_r[p]   <= 1'b0;
        count_r[p]   <= '0;
        active_r[p]  <= 1'b0;
      end
    end else if (wr_en) begin
      addr_hi_r[idx_r] <= entry_nxt.addr_hi;
      addr_lo_r[idx_r] <= entry_nxt.addr_lo;
      reach_r[idx_r]   <= entry_nxt.reachable;
      count_r[idx_r]   <= entry_nxt.count;
      active_r[idx_r]  <= entry_nxt.active;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (go && emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && emit) begin
      out_data_r <= res;
    end
  end

  // A taken request always starts the walk.
  a_accept_walks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == ST_WALK))
    else $error("request taken but sequencer did not start");

  // Going idle leaves the final result of the request in the output register.
  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_stall) |-> (out_valid && out_data.last))
    else $error("sequencer went idle without a final result");

  // Acknowledgement and discovery are never asked for together.
  a_ack_disc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.ack_wanted && out_data.send_discover))
    else $error("acknowledgement and discovery in one result");

  // An unreachable entry reports no port and no address.
  a_unreach_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.entry_reachable) |->
      ((out_data.entry_port == 2'd0) && (out_data.entry_addr_hi == '0) &&
       (out_data.entry_addr_lo == '0)))
    else $error("unreachable entry carries port or address");

endmodule

`default_nettype wire
